@@ hw/rtl/wrfb_pkg.sv @@
// Shared types and constants for the watch request frame builder.
package wrfb_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 50;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] STOP_BYTE = 8'h55;

    typedef struct packed {
        logic        first;
        logic        last;
        logic [5:0]  count;
        logic [7:0]  len;
        logic [31:0] addr;
        logic [7:0]  size;
    } wrfb_cmd_t;

endpackage

@@ hw/rtl/wrfb_front.sv @@
// Front end: accepts entries, drops strays, saturates the count and queues commands.
module wrfb_front
    import wrfb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first_entry,
    input  logic [5:0]  entry_count,
    input  logic [31:0] entry_address,
    input  logic [7:0]  data_size,
    input  logic        last_entry,
    input  logic        q_full,
    output logic        q_push,
    output wrfb_cmd_t   q_cmd,
    output logic        frame_open
);

    localparam logic [5:0] MAX_COUNT = 6'(MAX_ENTRIES);

    logic       frame_open_reg;
    logic       frame_open_next;
    logic       accept;
    logic       keep;
    logic [5:0] count_sat;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;
    assign keep = first_entry || frame_open_reg;
    assign q_push = accept && keep;
    assign count_sat = (entry_count > MAX_COUNT) ? MAX_COUNT : entry_count;
    assign frame_open = frame_open_reg;

    always_comb
    begin
        q_cmd.first = first_entry;
        q_cmd.last = last_entry;
        q_cmd.count = count_sat;
        q_cmd.len = {count_sat, 2'b00} + {2'b00, count_sat} + 8'd1;
        q_cmd.addr = entry_address;
        q_cmd.size = data_size;
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (q_push)
        begin
            frame_open_next = !last_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

@@ hw/rtl/wrfb_queue.sv @@
// Short command queue between the front and the back.
module wrfb_queue
    import wrfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wrfb_cmd_t  push_cmd,
    input  logic       pop,
    output wrfb_cmd_t  head,
    output logic       full,
    output logic       empty
);

    wrfb_cmd_t              entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic [QUEUE_CNT_W-1:0] cnt_next;

    assign full = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head = entries[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/wrfb_back.sv @@
// Back end: serializes queued commands into frame bytes with the running checksum.
module wrfb_back
    import wrfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] function_code,
    input  wrfb_cmd_t  head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_end
);

    typedef enum logic [3:0] {
        ST_START = 4'b0001,
        ST_HEAD  = 4'b0010,
        ST_BODY  = 4'b0100,
        ST_TAIL  = 4'b1000
    } wrfb_state_t;

    wrfb_state_t st_reg;
    wrfb_state_t st_next;
    wrfb_state_t phase;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [2:0]  idx;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_end_reg;
    logic        out_end_next;
    logic        adv;
    logic [7:0]  byte_sel;
    logic        end_sel;

    assign adv = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end = out_end_reg;

    always_comb
    begin
        if (st_reg == ST_START)
        begin
            phase = head.first ? ST_HEAD : ST_BODY;
            idx = 3'd0;
        end
        else
        begin
            phase = st_reg;
            idx = idx_reg;
        end
    end

    always_comb
    begin
        byte_sel = 8'h00;
        end_sel = 1'b0;
        sum_next = sum_reg;
        st_next = st_reg;
        idx_next = idx_reg;
        q_pop = 1'b0;
        case (phase)
            ST_HEAD:
            begin
                st_next = ST_HEAD;
                idx_next = idx + 3'd1;
                case (idx[1:0])
                    2'd0: byte_sel = START_BYTE;
                    2'd1: byte_sel = function_code;
                    2'd2: byte_sel = head.len;
                    default:
                    begin
                        byte_sel = {2'b00, head.count};
                        sum_next = {2'b00, head.count};
                        st_next = ST_BODY;
                        idx_next = 3'd0;
                    end
                endcase
            end
            ST_BODY:
            begin
                st_next = ST_BODY;
                idx_next = idx + 3'd1;
                case (idx)
                    3'd0: byte_sel = head.addr[7:0];
                    3'd1: byte_sel = head.addr[15:8];
                    3'd2: byte_sel = head.addr[23:16];
                    3'd3: byte_sel = head.addr[31:24];
                    default:
                    begin
                        byte_sel = head.size;
                        idx_next = 3'd0;
                        if (head.last)
                        begin
                            st_next = ST_TAIL;
                        end
                        else
                        begin
                            st_next = ST_START;
                            q_pop = adv;
                        end
                    end
                endcase
                sum_next = sum_reg + byte_sel;
            end
            ST_TAIL:
            begin
                if (idx == 3'd0)
                begin
                    byte_sel = sum_reg;
                    st_next = ST_TAIL;
                    idx_next = 3'd1;
                end
                else
                begin
                    byte_sel = STOP_BYTE;
                    end_sel = 1'b1;
                    sum_next = 8'h00;
                    st_next = ST_START;
                    idx_next = 3'd0;
                    q_pop = adv;
                end
            end
            default:
            begin
                st_next = ST_START;
                idx_next = 3'd0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next = out_byte_reg;
        out_end_next = out_end_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next = byte_sel;
            out_end_next = end_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_START;
            idx_reg <= 3'd0;
            sum_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                st_reg <= st_next;
                idx_reg <= idx_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_end_reg <= out_end_next;
    end

endmodule

@@ hw/rtl/watch_request_frame_builder_top.sv @@
// Watch request frame builder: takes one watch entry per transaction and emits
// the request frame one byte per transaction. A first entry adds the four header
// bytes (0xAA, function code, length, count), every entry adds its four address
// bytes low first and its size byte, and a last entry adds the checksum and the
// stop byte 0x55 flagged by frame_end. The output runs at one byte per cycle when
// the queue is not empty and out_stall does not hold the single byte-wide output
// register. A four-deep command queue lets entries be taken while earlier bytes
// are still going out. Entries other than a first entry that arrive with no frame
// open are dropped; counts above MAX_ENTRIES are clamped. Write function_code only
// while the block is idle.
module watch_request_frame_builder_top
    import wrfb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  function_code,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first_entry,
    input  logic [5:0]  entry_count,
    input  logic [31:0] entry_address,
    input  logic [7:0]  data_size,
    input  logic        last_entry,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_end
);

    logic [7:0] function_code_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    wrfb_cmd_t  push_cmd;
    wrfb_cmd_t  head;
    logic       frame_open;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            function_code_reg <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            function_code_reg <= function_code;
        end
    end

    wrfb_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_entry  (first_entry),
        .entry_count  (entry_count),
        .entry_address(entry_address),
        .data_size    (data_size),
        .last_entry   (last_entry),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd),
        .frame_open   (frame_open)
    );

    wrfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(push_cmd),
        .pop     (q_pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    wrfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .function_code(function_code_reg),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .frame_end    (frame_end)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_stray_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !first_entry && !frame_open) |-> !q_push)
        else $error("entry outside a frame was queued");

    a_end_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (frame_byte == STOP_BYTE))
        else $error("frame end flagged on a byte other than the stop byte");

endmodule

@@ tb/watch_request_frame_builder_top_tb.sv @@
// Self-checking testbench for the watch request frame builder: directed table, then random frames.
`timescale 1ns / 1ps

module watch_request_frame_builder_top_tb
    import wrfb_pkg::*;
();

    localparam int ENTRY_LIMIT = MAX_ENTRIES_DEFAULT;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int DIR_ROWS = 20;

    typedef struct packed {
        bit        first;
        bit [5:0]  count;
        bit [31:0] addr;
        bit [7:0]  size;
        bit        last;
        bit        known;
        bit [3:0]  n;
        bit [87:0] bytes_v;
    } entry_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       stop;
    } frame_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  function_code;
    logic        in_valid;
    logic        in_stall;
    logic        first_entry;
    logic [5:0]  entry_count;
    logic [31:0] entry_address;
    logic [7:0]  data_size;
    logic        last_entry;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        frame_end;

    logic        hold_off;
    int          snd_idle_pct;
    int          rcv_stall_pct;
    int          mismatches;
    int          productive_entries;

    logic [7:0]  code_reg;
    logic [7:0]  checksum_acc;
    logic        frame_is_open;
    logic [7:0]  pred_bytes [0:10];
    logic        pred_stop [0:10];
    int          pred_n;

    frame_beat_t pending_beats [$];
    entry_row_t  dir_table [0:DIR_ROWS-1];

    watch_request_frame_builder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .function_code (function_code),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_entry   (first_entry),
        .entry_count   (entry_count),
        .entry_address (entry_address),
        .data_size     (data_size),
        .last_entry    (last_entry),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .frame_end     (frame_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void add_pred_byte(input logic [7:0] b, input logic stop);
        pred_bytes[pred_n] = b;
        pred_stop[pred_n] = stop;
        pred_n++;
    endfunction

    task automatic serialize_entry(input entry_row_t r);
        logic [7:0] cnt;
        logic [7:0] sum;
        pred_n = 0;
        if (r.first)
        begin
            cnt = (r.count > ENTRY_LIMIT) ? 8'(ENTRY_LIMIT) : 8'(r.count);
            add_pred_byte(START_BYTE, 1'b0);
            add_pred_byte(code_reg, 1'b0);
            add_pred_byte(cnt * 8'd5 + 8'd1, 1'b0);
            add_pred_byte(cnt, 1'b0);
            checksum_acc = cnt;
            frame_is_open = 1'b1;
        end
        else if (!frame_is_open)
        begin
            return;
        end
        sum = checksum_acc;
        for (int i = 0; i < 4; i++)
        begin
            add_pred_byte(r.addr[8*i +: 8], 1'b0);
            sum = sum + r.addr[8*i +: 8];
        end
        add_pred_byte(r.size, 1'b0);
        sum = sum + r.size;
        checksum_acc = sum;
        if (r.last)
        begin
            add_pred_byte(checksum_acc, 1'b0);
            add_pred_byte(STOP_BYTE, 1'b1);
            checksum_acc = 8'd0;
            frame_is_open = 1'b0;
        end
    endtask

    task automatic send_entry(input entry_row_t r);
        frame_beat_t beat;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_entry <= r.first;
        entry_count <= r.count;
        entry_address <= r.addr;
        data_size <= r.size;
        last_entry <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        serialize_entry(r);
        if (pred_n != 0)
            productive_entries++;
        if (r.known)
        begin
            for (int i = 0; i < r.n; i++)
            begin
                beat.data = r.bytes_v[87 - 8*i -: 8];
                beat.stop = r.last && (i == r.n - 1);
                pending_beats.push_back(beat);
            end
        end
        else
        begin
            for (int i = 0; i < pred_n; i++)
            begin
                beat.data = pred_bytes[i];
                beat.stop = pred_stop[i];
                pending_beats.push_back(beat);
            end
        end
    endtask

    task automatic send_random_traffic(input int target);
        int goal;
        int n;
        bit abandon;
        logic [5:0] cnt;
        entry_row_t r;
        goal = productive_entries + target;
        while (productive_entries < goal)
        begin
            r = '0;
            if ($urandom_range(0, 99) < 8)
            begin
                r.count = 6'($urandom_range(0, 63));
                r.addr = $urandom;
                r.size = 8'($urandom_range(0, 255));
                r.last = 1'($urandom_range(0, 1));
                send_entry(r);
            end
            else
            begin
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(5, ENTRY_LIMIT)
                                                 : $urandom_range(1, 4);
                abandon = ($urandom_range(0, 9) == 0);
                cnt = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) : 6'(n);
                for (int i = 0; i < n; i++)
                begin
                    r.first = (i == 0);
                    r.count = (i == 0) ? cnt : 6'($urandom_range(0, 63));
                    r.addr = $urandom;
                    r.size = 8'($urandom_range(0, 255));
                    r.last = (i == n - 1) && !abandon;
                    send_entry(r);
                end
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_function_code(input logic [7:0] v);
        cfg_valid <= 1'b1;
        function_code <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        code_reg = v;
    endtask

    always @(posedge clk)
    begin
        frame_beat_t beat;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_beats.size() == 0)
                begin
                    $error("unexpected transaction: frame_byte %h frame_end %b",
                           frame_byte, frame_end);
                    mismatches++;
                end
                else
                begin
                    beat = pending_beats.pop_front();
                    if (frame_byte !== beat.data)
                    begin
                        $error("frame_byte expected %h actual %h", beat.data, frame_byte);
                        mismatches++;
                    end
                    if (frame_end !== beat.stop)
                    begin
                        $error("frame_end expected %b actual %b", beat.stop, frame_end);
                        mismatches++;
                    end
                end
            end
            out_stall <= hold_off || ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        function_code = 8'd0;
        in_valid = 1'b0;
        first_entry = 1'b0;
        entry_count = 6'd0;
        entry_address = 32'd0;
        data_size = 8'd0;
        last_entry = 1'b0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        snd_idle_pct = 9;
        rcv_stall_pct = 56;
        mismatches = 0;
        productive_entries = 0;
        code_reg = 8'd0;
        checksum_acc = 8'd0;
        frame_is_open = 1'b0;
        pred_n = 0;

        // first, count, addr, size, last, known, n, typed bytes
        dir_table = '{
            '{1'b0, 6'd5,  32'hDEADBEEF, 8'h04, 1'b0, 1'b1, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'h00000000, 8'h00, 1'b1, 1'b1, 4'd0,  88'h0},
            '{1'b1, 6'd0,  32'h00000000, 8'h00, 1'b1, 1'b1, 4'd11,
              88'hAA_00_01_00_00_00_00_00_00_00_55},
            '{1'b1, 6'd63, 32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 4'd11,
              88'hAA_00_FB_32_FF_FF_FF_FF_FF_2D_55},
            '{1'b1, 6'd50, 32'h12345678, 8'h04, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'h80000001, 8'h80, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd63, 32'h00FF00FF, 8'h01, 1'b1, 1'b0, 4'd0,  88'h0},
            '{1'b1, 6'd51, 32'h00000000, 8'h00, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b1, 6'd1,  32'hA5A5A5A5, 8'h02, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'h5A5A5A5A, 8'h08, 1'b1, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd7,  32'hCAFEF00D, 8'h10, 1'b0, 1'b1, 4'd0,  88'h0},
            '{1'b1, 6'd3,  32'h01020304, 8'h04, 1'b1, 1'b0, 4'd0,  88'h0},
            '{1'b1, 6'd1,  32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 4'd11,
              88'hAA_00_06_01_FF_FF_FF_FF_FF_FC_55},
            '{1'b1, 6'd2,  32'h7FFFFFFF, 8'h7F, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd2,  32'h0000FFFF, 8'h20, 1'b1, 1'b0, 4'd0,  88'h0},
            '{1'b1, 6'd10, 32'h33333333, 8'h40, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'hCCCCCCCC, 8'h02, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'hF0F0F0F0, 8'h01, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b1, 6'd32, 32'h0F0F0F0F, 8'h04, 1'b0, 1'b0, 4'd0,  88'h0},
            '{1'b0, 6'd0,  32'h89ABCDEF, 8'hFE, 1'b1, 1'b0, 4'd0,  88'h0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_function_code(8'h00);
        for (int i = 0; i < DIR_ROWS; i++)
            send_entry(dir_table[i]);
        in_valid <= 1'b0;
        wait_drained();

        write_function_code(8'hFF);
        send_random_traffic(120);
        wait_drained();

        snd_idle_pct = 56;
        rcv_stall_pct = 9;
        write_function_code(8'($urandom_range(1, 254)));
        send_random_traffic(120);
        wait_drained();

        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        write_function_code(8'($urandom_range(0, 255)));
        send_random_traffic(55);
        wait_drained();

        // hold the output while entries keep coming so the input side backs up
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_random_traffic(55);
        join
        wait_drained();

        if (pending_beats.size() != 0)
        begin
            $error("%0d expected transactions never arrived", pending_beats.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ watch_request_frame_builder_top.f @@
hw/rtl/wrfb_pkg.sv
hw/rtl/wrfb_front.sv
hw/rtl/wrfb_queue.sv
hw/rtl/wrfb_back.sv
hw/rtl/watch_request_frame_builder_top.sv
tb/watch_request_frame_builder_top_tb.sv
